>>> design/sliding_window_rate_limiter_top_macros.svh
// ----------------------------------------------------------------------------
// sliding window rate limiter assertion macros
// shared property shapes for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_LIMITER_TOP_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMITER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SWRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SWRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/swrl_pkg.sv
// ----------------------------------------------------------------------------
// swrl_pkg
// types and constants shared by the rate limiter cell chain and controller
// ----------------------------------------------------------------------------
`default_nettype none

package swrl_pkg;

  localparam int unsigned TS_W = 32;

  // item function codes
  localparam logic [1:0] FUNC_CHECK  = 2'd0;
  localparam logic [1:0] FUNC_RECORD = 2'd1;
  localparam logic [1:0] FUNC_VIOL   = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_OK     = 2'd0;
  localparam logic [1:0] VERDICT_BANNED = 2'd1;
  localparam logic [1:0] VERDICT_SHORT  = 2'd2;
  localparam logic [1:0] VERDICT_LONG   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MAX_SHORT  = 3'd0;
  localparam logic [2:0] REG_MAX_LONG   = 3'd1;
  localparam logic [2:0] REG_SHORT_WIN  = 3'd2;
  localparam logic [2:0] REG_LONG_WIN   = 3'd3;
  localparam logic [2:0] REG_BAN_LEN    = 3'd4;
  localparam logic [2:0] REG_VIOL_LIMIT = 3'd5;

  // register reset values
  localparam logic [6:0]      RST_MAX_SHORT  = 7'd10;
  localparam logic [6:0]      RST_MAX_LONG   = 7'd60;
  localparam logic [TS_W-1:0] RST_SHORT_WIN  = 32'd1000;
  localparam logic [TS_W-1:0] RST_LONG_WIN   = 32'd60000;
  localparam logic [TS_W-1:0] RST_BAN_LEN    = 32'd300000;
  localparam logic [7:0]      RST_VIOL_LIMIT = 8'd3;

  localparam logic [7:0] VIOL_MAX = 8'hFF;

  // what each cell does as the sweep passes it
  typedef enum logic [2:0] {
    MODE_PRUNE  = 3'b001,
    MODE_COUNT  = 3'b010,
    MODE_INSERT = 3'b100
  } mode_e;

  // values broadcast to every cell; user holds windows stable during a sweep
  typedef struct packed {
    mode_e           mode;
    logic [TS_W-1:0] now;
    logic [TS_W-1:0] short_window;
    logic [TS_W-1:0] long_window;
  } bcast_t;

  // sweep token handed from cell to cell
  typedef struct packed {
    logic act;
    logic carry_v;
  } wave_t;

endpackage

`default_nettype wire

>>> design/swrl_cell.sv
// ----------------------------------------------------------------------------
// swrl_cell
// one log slot: prunes, inserts by swap, and adds its hits to the running counts
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_rate_limiter_top_macros.svh"

module swrl_cell #(
  parameter int unsigned CW  = 7,
  parameter int unsigned IDX = 0
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  swrl_pkg::bcast_t             bc_i,
  input  swrl_pkg::wave_t              w_i,
  input  wire [swrl_pkg::TS_W-1:0]     carry_s_i,
  input  wire [CW-1:0]                 short_i,
  input  wire [CW-1:0]                 long_i,
  output swrl_pkg::wave_t              w_o,
  output logic [swrl_pkg::TS_W-1:0]    carry_s_o,
  output logic [CW-1:0]                short_o,
  output logic [CW-1:0]                long_o
);

  logic                      v_q;
  logic [swrl_pkg::TS_W-1:0] s_q;
  logic                      nv;
  logic [swrl_pkg::TS_W-1:0] ns;
  logic                      cov;
  logic [swrl_pkg::TS_W-1:0] age_old;
  logic [swrl_pkg::TS_W-1:0] age_new;
  logic                      short_hit;
  swrl_pkg::wave_t           w_q;
  logic [swrl_pkg::TS_W-1:0] carry_q;
  logic [CW-1:0]             short_q;
  logic [CW-1:0]             long_q;

  // new slot content for the passing sweep
  always_comb begin
    nv      = v_q;
    ns      = s_q;
    cov     = 1'b0;
    age_old = bc_i.now - s_q;
    unique case (bc_i.mode)
      swrl_pkg::MODE_PRUNE: begin
        nv = v_q && (age_old <= bc_i.long_window);
      end
      swrl_pkg::MODE_INSERT: begin
        if (w_i.carry_v) begin
          nv  = 1'b1;
          ns  = carry_s_i;
          cov = v_q;
        end
      end
      swrl_pkg::MODE_COUNT: begin
        nv = v_q;
      end
      default: begin
        nv = v_q;
      end
    endcase
    age_new   = bc_i.now - ns;
    short_hit = nv && (age_new <= bc_i.short_window);
  end

  // slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (w_i.act) begin
      v_q <= nv;
    end
  end

  // slot stamp
  always_ff @(posedge clk_i) begin
    if (w_i.act) begin
      s_q <= ns;
    end
  end

  // sweep token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else begin
      w_q.act     <= w_i.act;
      w_q.carry_v <= w_i.act & cov;
    end
  end

  // carried entry and running counts
  always_ff @(posedge clk_i) begin
    carry_q <= s_q;
    short_q <= short_i + CW'(short_hit);
    long_q  <= long_i + CW'(nv);
  end

  assign w_o       = w_q;
  assign carry_s_o = carry_q;
  assign short_o   = short_q;
  assign long_o    = long_q;

  // counts cannot exceed the cells already passed
  `SWRL_ASSERT_IMP(a_long_bound, w_q.act, int'(long_q) <= int'(IDX) + 1, "long count overrun")
  `SWRL_ASSERT_IMP(a_short_le_long, w_q.act, short_q <= long_q, "short count above long count")

endmodule

`default_nettype wire

>>> design/swrl_ctrl.sv
// ----------------------------------------------------------------------------
// swrl_ctrl
// handshakes, configuration, ban state, sweep launch and verdict
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_rate_limiter_top_macros.svh"

module swrl_ctrl #(
  parameter int unsigned CW = 7
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // input stream
  input  wire                       s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire [31:0]                s_axis_tdata,   // [31:0] now_ms
  input  wire [1:0]                 s_axis_tuser,   // [1:0] func
  // result stream
  output logic                      m_axis_tvalid,
  input  wire                       m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // [1:0] verdict, [8:2] short_count,
                                                    // [15:9] long_count, [16] ban_active
  // configuration writes
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire [2:0]                 cfg_index_i,
  input  wire [31:0]                cfg_data_i,
  // cell chain
  output swrl_pkg::bcast_t          bc_o,
  output swrl_pkg::wave_t           w_head_o,
  input  swrl_pkg::wave_t           w_tail_i,
  input  wire [CW-1:0]              short_i,
  input  wire [CW-1:0]              long_i
);

  localparam int unsigned XW = (CW > 7) ? CW : 7;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DONE  = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic                      launch_q;
  swrl_pkg::mode_e           mode_q, mode_d;
  logic [swrl_pkg::TS_W-1:0] now_q;
  logic [1:0]                func_q;
  logic                      holds_q, holds;
  logic                      banned_q, banned_d;
  logic [swrl_pkg::TS_W-1:0] ban_until_q, ban_until_d;
  logic [7:0]                viol_q, viol_d, viol_inc;
  logic [swrl_pkg::TS_W-1:0] ban_diff;
  logic                      in_xfer;
  logic                      out_load;

  logic [6:0]                max_short_q, max_long_q;
  logic [swrl_pkg::TS_W-1:0] short_win_q, long_win_q, ban_len_q;
  logic [7:0]                viol_limit_q;

  logic [XW-1:0]             short_x, long_x;
  logic [1:0]                verdict;
  logic [23:0]               pend_q;
  logic                      out_valid_q;
  logic [23:0]               out_q;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_short_q  <= swrl_pkg::RST_MAX_SHORT;
      max_long_q   <= swrl_pkg::RST_MAX_LONG;
      short_win_q  <= swrl_pkg::RST_SHORT_WIN;
      long_win_q   <= swrl_pkg::RST_LONG_WIN;
      ban_len_q    <= swrl_pkg::RST_BAN_LEN;
      viol_limit_q <= swrl_pkg::RST_VIOL_LIMIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        swrl_pkg::REG_MAX_SHORT:  max_short_q  <= cfg_data_i[6:0];
        swrl_pkg::REG_MAX_LONG:   max_long_q   <= cfg_data_i[6:0];
        swrl_pkg::REG_SHORT_WIN:  short_win_q  <= cfg_data_i;
        swrl_pkg::REG_LONG_WIN:   long_win_q   <= cfg_data_i;
        swrl_pkg::REG_BAN_LEN:    ban_len_q    <= cfg_data_i;
        swrl_pkg::REG_VIOL_LIMIT: viol_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ban test and state update on an input transfer
  always_comb begin
    ban_diff    = s_axis_tdata - ban_until_q;
    holds       = banned_q && ban_diff[swrl_pkg::TS_W-1];
    banned_d    = banned_q;
    ban_until_d = ban_until_q;
    viol_d      = viol_q;
    viol_inc    = (viol_q != swrl_pkg::VIOL_MAX) ? viol_q + 8'd1 : viol_q;
    mode_d      = swrl_pkg::MODE_COUNT;
    unique case (s_axis_tuser)
      swrl_pkg::FUNC_CHECK: begin
        if (!holds) begin
          mode_d   = swrl_pkg::MODE_PRUNE;
          banned_d = 1'b0;
          if (banned_q) begin
            viol_d = '0;
          end
        end
      end
      swrl_pkg::FUNC_RECORD: begin
        mode_d = swrl_pkg::MODE_INSERT;
      end
      swrl_pkg::FUNC_VIOL: begin
        viol_d = viol_inc;
        if (viol_inc >= viol_limit_q) begin
          banned_d    = 1'b1;
          ban_until_d = s_axis_tdata + ban_len_q;
        end
      end
      default: ;
    endcase
  end

  // ban state and item registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banned_q    <= 1'b0;
      ban_until_q <= '0;
      viol_q      <= '0;
      mode_q      <= swrl_pkg::MODE_COUNT;
      func_q      <= swrl_pkg::FUNC_CHECK;
      holds_q     <= 1'b0;
      now_q       <= '0;
    end else if (in_xfer) begin
      banned_q    <= banned_d;
      ban_until_q <= ban_until_d;
      viol_q      <= viol_d;
      mode_q      <= mode_d;
      func_q      <= s_axis_tuser;
      holds_q     <= holds;
      now_q       <= s_axis_tdata;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_xfer)       state_d = ST_SWEEP;
      ST_SWEEP: if (w_tail_i.act)  state_d = ST_DONE;
      ST_DONE:  if (out_load)      state_d = ST_IDLE;
      default:                     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= in_xfer;
    end
  end

  // broadcast and sweep head
  assign bc_o.mode         = mode_q;
  assign bc_o.now          = now_q;
  assign bc_o.short_window = short_win_q;
  assign bc_o.long_window  = long_win_q;
  assign w_head_o.act      = launch_q;
  assign w_head_o.carry_v  = (mode_q == swrl_pkg::MODE_INSERT);

  // verdict from the counts at the chain tail
  always_comb begin
    short_x = XW'(short_i);
    long_x  = XW'(long_i);
    verdict = swrl_pkg::VERDICT_OK;
    if (func_q == swrl_pkg::FUNC_CHECK) begin
      priority if (holds_q) begin
        verdict = swrl_pkg::VERDICT_BANNED;
      end else if (short_x >= XW'(max_short_q)) begin
        verdict = swrl_pkg::VERDICT_SHORT;
      end else if (long_x >= XW'(max_long_q)) begin
        verdict = swrl_pkg::VERDICT_LONG;
      end else begin
        verdict = swrl_pkg::VERDICT_OK;
      end
    end
  end

  // finished result waiting for the output register
  always_ff @(posedge clk_i) begin
    if (w_tail_i.act) begin
      pend_q[1:0]   <= verdict;
      pend_q[8:2]   <= (short_x > XW'(127)) ? 7'd127 : short_x[6:0];
      pend_q[15:9]  <= (long_x > XW'(127)) ? 7'd127 : long_x[6:0];
      pend_q[16]    <= banned_q;
      pend_q[23:17] <= '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  `SWRL_ASSERT_IMP(a_tail_in_sweep, w_tail_i.act, state_q == ST_SWEEP, "sweep ended outside sweep")
  `SWRL_ASSERT_NXT(a_launch_once, launch_q, !launch_q, "sweep launched twice")
  `SWRL_ASSERT_NXT(a_ban_cleared, in_xfer && (s_axis_tuser == swrl_pkg::FUNC_CHECK) && !holds,
                   !banned_q, "expired ban not cleared")

endmodule

`default_nettype wire

>>> design/sliding_window_rate_limiter_top.sv
// flow: an input transfer launches a sweep; the tail token loads the pending result,
// which enters the output register once it is free; only then is a new item taken
// each cell holds one log slot; a token walks the chain one cell per cycle
// reset: asynchronous active low, empties the log, clears the ban, loads register defaults
// no clearing pass: of the cell registers only slot valid bits and sweep tokens are reset
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_top
// sliding window log rate limiter for one client built as a row of slot cells
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_rate_limiter_top #(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [31:0]  s_axis_tdata,   // [31:0] now_ms
  input  wire [1:0]   s_axis_tuser,   // [1:0] func
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] verdict, [8:2] short_count,
                                      // [15:9] long_count, [16] ban_active
  // configuration writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire [2:0]   cfg_index_i,
  input  wire [31:0]  cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);

  swrl_pkg::bcast_t          bc;
  swrl_pkg::wave_t           w     [0:LOG_DEPTH];
  logic [swrl_pkg::TS_W-1:0] cs    [0:LOG_DEPTH-1];
  logic [CNT_W-1:0]          sc    [0:LOG_DEPTH];
  logic [CNT_W-1:0]          lc    [0:LOG_DEPTH];

  // controller
  swrl_ctrl #(
    .CW (CNT_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .bc_o          (bc),
    .w_head_o      (w[0]),
    .w_tail_i      (w[LOG_DEPTH]),
    .short_i       (sc[LOG_DEPTH]),
    .long_i        (lc[LOG_DEPTH])
  );

  // chain head: new stamp enters as the carry, counts start at zero
  assign cs[0] = bc.now;
  assign sc[0] = '0;
  assign lc[0] = '0;

  // slot cells, newest entry at the head
  for (genvar g = 0; g < LOG_DEPTH; g++) begin : g_cell
    if (g < LOG_DEPTH - 1) begin : g_mid
      swrl_cell #(
        .CW  (CNT_W),
        .IDX (g)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .bc_i      (bc),
        .w_i       (w[g]),
        .carry_s_i (cs[g]),
        .short_i   (sc[g]),
        .long_i    (lc[g]),
        .w_o       (w[g+1]),
        .carry_s_o (cs[g+1]),
        .short_o   (sc[g+1]),
        .long_o    (lc[g+1])
      );
    end else begin : g_last
      // the oldest entry falls off here when the log is full
      swrl_cell #(
        .CW  (CNT_W),
        .IDX (g)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .bc_i      (bc),
        .w_i       (w[g]),
        .carry_s_i (cs[g]),
        .short_i   (sc[g]),
        .long_i    (lc[g]),
        .w_o       (w[g+1]),
        .carry_s_o (),
        .short_o   (sc[g+1]),
        .long_o    (lc[g+1])
      );
    end
  end

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// sliding window rate limiter testbench
// drives check, record and violation requests into the limiter under several
// register settings and random backpressure; results are compared with a table
// row or a model of the timestamp log, ban and violation count kept in here
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LOG_DEPTH    = 64;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = LOG_DEPTH + 8;
  localparam int unsigned REPORT_MAX   = 10;

  // codes the block must tolerate and ignore
  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // result fields, same order as m_axis_tdata[16:0]
  typedef struct packed {
    logic       ban_active;
    logic [6:0] long_count;
    logic [6:0] short_count;
    logic [1:0] verdict;
  } outcome_t;

  // one row of the opening stimulus table
  typedef struct {
    logic [1:0]  func;
    logic [31:0] now_ms;
    bit          typed;
    outcome_t    want;
  } probe_t;

  // one register setting and the traffic shape run under it
  typedef struct {
    logic [6:0]  max_short;
    logic [6:0]  max_long;
    logic [31:0] short_win;
    logic [31:0] long_win;
    logic [31:0] ban_len;
    logic [7:0]  viol_limit;
    int unsigned items;
    int unsigned step_max;
    int unsigned chk_pct;
    int unsigned rec_pct;
    int unsigned viol_pct;
  } setting_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] now_ms
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [1:0] verdict, [8:2] short_count,
                                     // [15:9] long_count, [16] ban_active
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;

  // limiter model state
  logic [31:0] stamp_q[$];
  logic        banned_m;
  logic [31:0] ban_end_m;
  logic [7:0]  strikes_m;
  logic [6:0]  lim_short;
  logic [6:0]  lim_long;
  logic [31:0] win_short;
  logic [31:0] win_long;
  logic [31:0] ban_span;
  logic [7:0]  strike_limit;

  // expected results in transfer order
  outcome_t    verdicts_due[$];

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned failures      = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned settings_run  = 0;
  int unsigned log_peak      = 0;
  int unsigned verdict_tally[4];
  logic [31:0] sim_ms        = '0;

  sliding_window_rate_limiter_top #(
    .LOG_DEPTH(LOG_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // log entries no older than the short window
  function automatic int unsigned recent_stamps(logic [31:0] now);
    int unsigned n;
    logic [31:0] age;
    n = 0;
    foreach (stamp_q[k]) begin
      age = now - stamp_q[k];
      if (age <= win_short) n++;
    end
    return n;
  endfunction

  // apply one request to the limiter model and form its result
  function automatic outcome_t rate_verdict(logic [1:0] fn, logic [31:0] now);
    outcome_t    o;
    logic [31:0] kept[$];
    logic [31:0] ban_left;
    logic [31:0] age;
    int unsigned shorts;
    o.verdict = swrl_pkg::VERDICT_OK;
    if (fn == swrl_pkg::FUNC_CHECK) begin
      ban_left = now - ban_end_m;
      if (banned_m && ban_left[31]) begin
        o.verdict = swrl_pkg::VERDICT_BANNED;
        shorts = recent_stamps(now);
      end else begin
        // ban over: forget it and the strikes, then judge normally
        if (banned_m) begin
          banned_m  = 1'b0;
          strikes_m = '0;
        end
        foreach (stamp_q[k]) begin
          age = now - stamp_q[k];
          if (age <= win_long) kept.push_back(stamp_q[k]);
        end
        stamp_q = kept;
        shorts = recent_stamps(now);
        if (shorts >= lim_short) o.verdict = swrl_pkg::VERDICT_SHORT;
        else if (stamp_q.size() >= lim_long) o.verdict = swrl_pkg::VERDICT_LONG;
      end
    end else begin
      if (fn == swrl_pkg::FUNC_RECORD) begin
        // full log drops its oldest stamp
        if (stamp_q.size() >= LOG_DEPTH) void'(stamp_q.pop_front());
        stamp_q.push_back(now);
      end else if (fn == swrl_pkg::FUNC_VIOL) begin
        if (strikes_m != swrl_pkg::VIOL_MAX) strikes_m++;
        if (strikes_m >= strike_limit) begin
          banned_m  = 1'b1;
          ban_end_m = now + ban_span;
        end
      end
      shorts = recent_stamps(now);
    end
    o.short_count = (shorts > 127) ? 7'd127 : shorts[6:0];
    o.long_count  = (stamp_q.size() > 127) ? 7'd127 : 7'(stamp_q.size());
    o.ban_active  = banned_m;
    return o;
  endfunction

  function automatic probe_t row(logic [1:0] fn, logic [31:0] ts, bit typed, outcome_t want);
    probe_t p;
    p.func   = fn;
    p.now_ms = ts;
    p.typed  = typed;
    p.want   = want;
    return p;
  endfunction

  function automatic setting_t make_setting(
    logic [6:0] ms, logic [6:0] ml, logic [31:0] sw, logic [31:0] lw, logic [31:0] bl,
    logic [7:0] vl, int unsigned n, int unsigned step, int unsigned chk, int unsigned rec,
    int unsigned viol
  );
    setting_t s;
    s.max_short  = ms;
    s.max_long   = ml;
    s.short_win  = sw;
    s.long_win   = lw;
    s.ban_len    = bl;
    s.viol_limit = vl;
    s.items      = n;
    s.step_max   = step;
    s.chk_pct    = chk;
    s.rec_pct    = rec;
    s.viol_pct   = viol;
    return s;
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // one register write transfer; valid stays up for back-to-back writes
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      swrl_pkg::REG_MAX_SHORT:  lim_short    = data[6:0];
      swrl_pkg::REG_MAX_LONG:   lim_long     = data[6:0];
      swrl_pkg::REG_SHORT_WIN:  win_short    = data;
      swrl_pkg::REG_LONG_WIN:   win_long     = data;
      swrl_pkg::REG_BAN_LEN:    ban_span     = data;
      swrl_pkg::REG_VIOL_LIMIT: strike_limit = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(swrl_pkg::REG_MAX_SHORT, 32'(s.max_short));
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(swrl_pkg::REG_MAX_LONG, 32'(s.max_long));
    write_reg(swrl_pkg::REG_SHORT_WIN, s.short_win);
    write_reg(swrl_pkg::REG_LONG_WIN, s.long_win);
    write_reg(swrl_pkg::REG_BAN_LEN, s.ban_len);
    write_reg(REG_SPARE_HI, $urandom);
    write_reg(swrl_pkg::REG_VIOL_LIMIT, 32'(s.viol_limit));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  // present one request, with random sender gaps, and queue its result
  task automatic send_item(logic [1:0] fn, logic [31:0] ts, bit typed, outcome_t want);
    outcome_t due;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ts;
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    due = rate_verdict(fn, ts);
    if (typed) due = want;
    verdicts_due.push_back(due);
    items_sent++;
    verdict_tally[due.verdict]++;
    if (stamp_q.size() > log_peak) log_peak = stamp_q.size();
  endtask

  // stop sending and wait until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  // mostly ordered time with small steps, some jumps, stale and wild stamps
  task automatic run_traffic(setting_t s);
    int unsigned roll;
    int unsigned noise;
    logic [1:0]  fn;
    logic [31:0] ts;
    for (int unsigned i = 0; i < s.items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < s.chk_pct) fn = swrl_pkg::FUNC_CHECK;
      else if (roll < s.chk_pct + s.rec_pct) fn = swrl_pkg::FUNC_RECORD;
      else if (roll < s.chk_pct + s.rec_pct + s.viol_pct) fn = swrl_pkg::FUNC_VIOL;
      else fn = FUNC_UNKNOWN;
      noise = $urandom_range(0, 99);
      if (noise < 4) begin
        ts = $urandom;
      end else if (noise < 8) begin
        ts = sim_ms - $urandom_range(0, 3000);
      end else begin
        if (noise < 12) sim_ms += $urandom_range(0, 400000);
        else sim_ms += $urandom_range(0, s.step_max);
        ts = sim_ms;
      end
      send_item(fn, ts, 1'b0, '0);
    end
  endtask

  // result sink backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // result checker
  outcome_t seen_now;
  outcome_t want_now;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_now = m_axis_tdata[16:0];
      if (verdicts_due.size() == 0) begin
        note_failure($sformatf("result %0d arrived with nothing pending (data %h)",
                               results_seen, m_axis_tdata));
      end else begin
        want_now = verdicts_due.pop_front();
        if (seen_now.verdict !== want_now.verdict)
          note_failure($sformatf("result %0d verdict: expected %0d, got %0d",
                                 results_seen, want_now.verdict, seen_now.verdict));
        if (seen_now.short_count !== want_now.short_count)
          note_failure($sformatf("result %0d short_count: expected %0d, got %0d",
                                 results_seen, want_now.short_count, seen_now.short_count));
        if (seen_now.long_count !== want_now.long_count)
          note_failure($sformatf("result %0d long_count: expected %0d, got %0d",
                                 results_seen, want_now.long_count, seen_now.long_count));
        if (seen_now.ban_active !== want_now.ban_active)
          note_failure($sformatf("result %0d ban_active: expected %0d, got %0d",
                                 results_seen, want_now.ban_active, seen_now.ban_active));
      end
      results_seen++;
    end
  end

  // run length guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("run stopped after %0d cycles with %0d results pending",
             CYCLE_LIMIT, verdicts_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    probe_t   opening_rows[$];
    setting_t plan[$];
    outcome_t empty_log;
    outcome_t one_stamp;

    // model at reset
    lim_short    = swrl_pkg::RST_MAX_SHORT;
    lim_long     = swrl_pkg::RST_MAX_LONG;
    win_short    = swrl_pkg::RST_SHORT_WIN;
    win_long     = swrl_pkg::RST_LONG_WIN;
    ban_span     = swrl_pkg::RST_BAN_LEN;
    strike_limit = swrl_pkg::RST_VIOL_LIMIT;
    stamp_q.delete();
    banned_m     = 1'b0;
    ban_end_m    = '0;
    strikes_m    = '0;
    foreach (verdict_tally[v]) verdict_tally[v] = 0;

    empty_log = '{ban_active: 1'b0, long_count: 7'd0, short_count: 7'd0,
                  verdict: swrl_pkg::VERDICT_OK};
    one_stamp = '{ban_active: 1'b0, long_count: 7'd1, short_count: 7'd1,
                  verdict: swrl_pkg::VERDICT_OK};

    // opening table under reset register values
    opening_rows.push_back(row(swrl_pkg::FUNC_CHECK, 32'd0, 1'b1, empty_log));
    opening_rows.push_back(row(swrl_pkg::FUNC_RECORD, 32'd0, 1'b1, one_stamp));
    // stamp at zero sits just past the wrap, looks very old from the top of time
    // and gets pruned
    opening_rows.push_back(row(swrl_pkg::FUNC_RECORD, 32'hFFFF_FFFF, 1'b0, '0));
    opening_rows.push_back(row(swrl_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 1'b0, '0));
    opening_rows.push_back(row(FUNC_UNKNOWN, 32'd12345, 1'b0, '0));
    for (int k = 0; k < 9; k++)
      opening_rows.push_back(row(swrl_pkg::FUNC_RECORD, 32'd2000 + k, 1'b0, '0));
    opening_rows.push_back(row(swrl_pkg::FUNC_CHECK, 32'd2010, 1'b0, '0));
    // tenth stamp in the short window trips the short limit
    opening_rows.push_back(row(swrl_pkg::FUNC_RECORD, 32'd2010, 1'b0, '0));
    opening_rows.push_back(row(swrl_pkg::FUNC_CHECK, 32'd2010, 1'b0, '0));
    // three strikes start a ban
    opening_rows.push_back(row(swrl_pkg::FUNC_VIOL, 32'd3000, 1'b0, '0));
    opening_rows.push_back(row(swrl_pkg::FUNC_VIOL, 32'd3001, 1'b0, '0));
    opening_rows.push_back(row(swrl_pkg::FUNC_VIOL, 32'd3002, 1'b0, '0));
    opening_rows.push_back(row(swrl_pkg::FUNC_CHECK, 32'd3003, 1'b0, '0));
    opening_rows.push_back(row(swrl_pkg::FUNC_RECORD, 32'd3004, 1'b0, '0));
    // check exactly at the ban end clears it and prunes the stale log
    opening_rows.push_back(row(swrl_pkg::FUNC_CHECK, 32'd303002, 1'b0, '0));
    opening_rows.push_back(row(swrl_pkg::FUNC_CHECK, 32'h7FFF_FFFF, 1'b0, '0));

    // settings: high extremes, low extremes, zero limits, mid, random, defaults
    plan.push_back(make_setting(7'd64, 7'd64, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                8'd255, 90, 50, 15, 80, 2));
    plan.push_back(make_setting(7'd1, 7'd1, 32'd1, 32'd1, 32'd0, 8'd1, 45, 2, 40, 40, 15));
    plan.push_back(make_setting(7'd12, 7'd0, 32'd500, 32'd5000, 32'd2000, 8'd0,
                                40, 200, 40, 40, 15));
    plan.push_back(make_setting(7'd0, 7'd20, 32'd300, 32'd4000, 32'd1500, 8'd2,
                                70, 60, 35, 50, 10));
    plan.push_back(make_setting(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                                $urandom_range(1, 5000), $urandom_range(1, 100000), $urandom,
                                8'($urandom_range(1, 8)), 65, 150, 35, 50, 10));
    plan.push_back(make_setting(swrl_pkg::RST_MAX_SHORT, swrl_pkg::RST_MAX_LONG,
                                swrl_pkg::RST_SHORT_WIN, swrl_pkg::RST_LONG_WIN,
                                swrl_pkg::RST_BAN_LEN, swrl_pkg::RST_VIOL_LIMIT,
                                65, 40, 30, 60, 7));

    // reset once
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    settings_run = 1;

    // sender idles more rarely than the receiver at first
    src_idle_pct  = 30;
    sink_idle_pct = 59;
    foreach (opening_rows[i])
      send_item(opening_rows[i].func, opening_rows[i].now_ms, opening_rows[i].typed,
                opening_rows[i].want);
    wait_drained();

    foreach (plan[p]) begin
      if (p == 2) begin
        src_idle_pct  = 59;
        sink_idle_pct = 30;
      end else if (p == 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      apply_setting(plan[p]);
      // last setting runs its time across the 32-bit wrap
      sim_ms = (p == plan.size() - 1) ? 32'hFFFF_FC00 : $urandom;
      run_traffic(plan[p]);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (verdicts_due.size() != 0) note_failure("results still pending at the end");

    $display("covered %0d requests over %0d register settings, %0d results checked",
             items_sent, settings_run, results_seen);
    $display("verdicts ok %0d, banned %0d, short limit %0d, long limit %0d; log peak %0d",
             verdict_tally[swrl_pkg::VERDICT_OK], verdict_tally[swrl_pkg::VERDICT_BANNED],
             verdict_tally[swrl_pkg::VERDICT_SHORT], verdict_tally[swrl_pkg::VERDICT_LONG],
             log_peak);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", failures);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
